// ----- design/rsad_pkg.sv -----
package rsad_pkg;

  localparam int SENSORS      = 8;
  localparam int RD_W         = 16;
  localparam int ANG_W        = 16;
  localparam int VEC_W        = 37;
  localparam int CORDIC_STAGES = 16;
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_LAT     = FRONT_STAGES + 1 + CORDIC_STAGES + 1;
  localparam int CFG_IDX_W    = 4;
  localparam logic [15:0] THRESHOLD_DEF = 16'd150;
  localparam logic signed [15:0] DIAG_Q15 = 16'sd23170;
  localparam logic [ANG_W-1:0] HALF_TURN = 16'd32768;

  typedef struct packed {
    logic [RD_W-1:0] reading_7;
    logic [RD_W-1:0] reading_6;
    logic [RD_W-1:0] reading_5;
    logic [RD_W-1:0] reading_4;
    logic [RD_W-1:0] reading_3;
    logic [RD_W-1:0] reading_2;
    logic [RD_W-1:0] reading_1;
    logic [RD_W-1:0] reading_0;
  } in_item_t;

  typedef struct packed {
    logic              line_found;
    logic [ANG_W-1:0]  avoid_angle;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
  } vec_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic             zero;
    logic [ANG_W-1:0] angle;
  } ang_t;

  function automatic logic [ANG_W-1:0] atan_entry(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 16'd8192;
      1:  v = 16'd4836;
      2:  v = 16'd2555;
      3:  v = 16'd1297;
      4:  v = 16'd651;
      5:  v = 16'd326;
      6:  v = 16'd163;
      7:  v = 16'd81;
      8:  v = 16'd41;
      9:  v = 16'd20;
      10: v = 16'd10;
      11: v = 16'd5;
      12: v = 16'd3;
      13: v = 16'd1;
      14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/rsad_front.sv -----
module rsad_front #(
  parameter logic [15:0] THRESHOLD = rsad_pkg::THRESHOLD_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  rsad_pkg::in_item_t                            in_data,
  input  logic [rsad_pkg::SENSORS-1:0][rsad_pkg::RD_W-1:0] baseline,
  output rsad_pkg::vec_t                                vec
);
  import rsad_pkg::*;

  logic [SENSORS-1:0][RD_W-1:0] rd;
  logic [SENSORS-1:0][RD_W-1:0] w_nxt;
  logic [SENSORS-1:0][RD_W-1:0] w_r;
  logic                         v1_r, f1_r, v2_r, f2_r, v3_r, f3_r, v4_r, f4_r;
  logic signed [16:0]           a_r, b_r, a3_r, b3_r;
  logic signed [17:0]           c_r, d_r;
  logic signed [32:0]           pc_r, pd_r;
  logic signed [VEC_W-1:0]      x_r, y_r;

  assign rd = in_data;

  always_comb begin
    logic signed [17:0] ex;
    for (int k = 0; k < SENSORS; k++) begin
      ex = $signed({2'b00, rd[k]}) - $signed({2'b00, baseline[k]})
           - $signed({2'b00, THRESHOLD});
      w_nxt[k] = (ex > 18'sd0) ? ex[RD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    a_r  <= $signed({1'b0, w_r[0]}) - $signed({1'b0, w_r[4]});
    b_r  <= $signed({1'b0, w_r[2]}) - $signed({1'b0, w_r[6]});
    c_r  <= $signed({2'b00, w_r[1]}) - $signed({2'b00, w_r[3]})
          - $signed({2'b00, w_r[5]}) + $signed({2'b00, w_r[7]});
    d_r  <= $signed({2'b00, w_r[1]}) + $signed({2'b00, w_r[3]})
          - $signed({2'b00, w_r[5]}) - $signed({2'b00, w_r[7]});
    a3_r <= a_r;
    b3_r <= b_r;
    pc_r <= 33'(c_r * DIAG_Q15);
    pd_r <= 33'(d_r * DIAG_Q15);
    x_r  <= ($signed(VEC_W'(a3_r)) <<< 15) + $signed(VEC_W'(pc_r));
    y_r  <= ($signed(VEC_W'(b3_r)) <<< 15) + $signed(VEC_W'(pd_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      f1_r <= 1'b0; f2_r <= 1'b0; f3_r <= 1'b0; f4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      f1_r <= |w_nxt;
      v2_r <= v1_r; f2_r <= f1_r;
      v3_r <= v2_r; f3_r <= f2_r;
      v4_r <= v3_r; f4_r <= f3_r;
    end
  end

  assign vec.valid = v4_r;
  assign vec.found = f4_r;
  assign vec.x     = x_r;
  assign vec.y     = y_r;

endmodule

// ----- design/rsad_cordic.sv -----
module rsad_cordic (
  input  logic            clk,
  input  logic            rst_n,
  input  rsad_pkg::vec_t  vec,
  output rsad_pkg::ang_t  ang
);
  import rsad_pkg::*;

  logic signed [VEC_W-1:0] x_r [0:CORDIC_STAGES];
  logic signed [VEC_W-1:0] y_r [0:CORDIC_STAGES];
  logic [ANG_W-1:0]        a_r [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0]  v_r, f_r, z_r;

  always_ff @(posedge clk) begin
    if (vec.x < 0) begin
      x_r[0] <= -vec.x;
      y_r[0] <= -vec.y;
      a_r[0] <= HALF_TURN;
    end else begin
      x_r[0] <= vec.x;
      y_r[0] <= vec.y;
      a_r[0] <= '0;
    end
    z_r[0] <= (vec.x == '0) && (vec.y == '0);
    f_r[0] <= vec.found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[CORDIC_STAGES-1:0], vec.valid};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + atan_entry(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - atan_entry(i);
      end
      z_r[i+1] <= z_r[i];
      f_r[i+1] <= f_r[i];
    end
  end

  assign ang.valid = v_r[CORDIC_STAGES];
  assign ang.found = f_r[CORDIC_STAGES];
  assign ang.zero  = z_r[CORDIC_STAGES];
  assign ang.angle = a_r[CORDIC_STAGES];

endmodule

// ----- design/ring_sensor_avoid_direction.sv -----
// Channel   Ports                              Timing
// request   start, busy, in_data               taken when start is high and busy low
// result    out_valid, out_data                one-cycle strobe, cannot be held off
// config    cfg_we, cfg_index, cfg_wdata       written on an edge with cfg_we high and cfg_index below 8, outside reset
// A request is taken every cycle; busy is always low.
// Each result passes through the weighting and vector-sum registers, the quadrant
// folding register, sixteen CORDIC stages and one output register.
// Reset clears the baselines to zero and empties the pipeline.
// Nothing stalls, since the receiver cannot hold results off.
module ring_sensor_avoid_direction #(
  parameter logic [15:0] THRESHOLD = rsad_pkg::THRESHOLD_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rsad_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  output rsad_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rsad_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsad_pkg::RD_W-1:0]          cfg_wdata
);
  import rsad_pkg::*;

  logic [SENSORS-1:0][RD_W-1:0] base_r;
  vec_t                         vec;
  ang_t                         ang;
  logic                         out_valid_r;
  out_item_t                    out_r, out_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(SENSORS))) begin
      base_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  rsad_front #(.THRESHOLD(THRESHOLD)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .baseline (base_r),
    .vec      (vec)
  );

  rsad_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .vec   (vec),
    .ang   (ang)
  );

  always_comb begin
    out_nxt.line_found = ang.found;
    if (!ang.found) begin
      out_nxt.avoid_angle = '0;
    end else if (ang.zero) begin
      out_nxt.avoid_angle = HALF_TURN;
    end else begin
      out_nxt.avoid_angle = ang.angle + HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ang.valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##PIPE_LAT out_valid) else $error("result missing after request");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ang.valid |-> $past(vec.valid, CORDIC_STAGES + 1)) else $error("result without request");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.line_found |-> out_data.avoid_angle == '0)
    else $error("angle set with no line");
`endif

endmodule
